/* src/rgbw_led_chain_bit_encoder_assert.svh */
// Assertion macros used by the checker file of the LED chain encoder.
// Each macro expects clk and rst to be visible where it is used.
`ifndef RGBW_LED_CHAIN_BIT_ENCODER_ASSERT_SVH
`define RGBW_LED_CHAIN_BIT_ENCODER_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define RLBE_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define RLBE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* src/rlbe_pkg.sv */
package rlbe_pkg;

  localparam int MAX_LEDS  = 256;
  localparam int LED_AW    = (MAX_LEDS > 1) ? $clog2(MAX_LEDS) : 1;
  localparam int CNT_W     = $clog2(MAX_LEDS + 1);
  localparam int MEM_AW    = LED_AW + 1;
  localparam int MEM_DEPTH = 2 ** MEM_AW;
  // MAX_LEDS never exceeds half the store, so MEM_AW bits hold every sweep value.
  localparam int SWP_W     = MEM_AW;

  localparam int CFG_W     = 12;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_ONE_HIGH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ZERO_HIGH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PAUSE     = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_WHITE     = 2'd3;

  localparam logic [9:0]  ONE_HIGH_RST  = 10'd58;
  localparam logic [9:0]  ZERO_HIGH_RST = 10'd33;
  localparam logic [11:0] PAUSE_RST     = 12'd72;

  localparam logic [5:0] BITS_RGBW = 6'd32;
  localparam logic [5:0] BITS_RGB  = 6'd24;

  localparam logic [2:0] ACT_WRITE_ONE  = 3'd0;
  localparam logic [2:0] ACT_FILL       = 3'd1;
  localparam logic [2:0] ACT_FILL_START = 3'd2;
  localparam logic [2:0] ACT_START      = 3'd3;
  localparam logic [2:0] ACT_TICK       = 3'd4;

  localparam logic [1:0] SLOT_NONE  = 2'd0;
  localparam logic [1:0] SLOT_DATA  = 2'd1;
  localparam logic [1:0] SLOT_PAUSE = 2'd2;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DISPATCH,
    ST_FILL,
    ST_START,
    ST_COPY,
    ST_COMMIT
  } state_t;

  typedef struct packed {
    logic idle;
    logic capture;
    logic sweep_clear;
    logic clr_step;
    logic fill_step;
    logic start_frame;
    logic start_reject;
    logic copy_step;
    logic tick_read;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic [2:0] action;
    logic       sending;
    logic       clr_last;
    logic       fill_done;
    logic       copy_done;
    logic       out_free;
  } status_t;

  function automatic logic [LED_AW-1:0] led_addr(input logic [7:0] idx);
    return LED_AW'(idx);
  endfunction

endpackage

/* src/rlbe_ctrl.sv */
module rlbe_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             item_valid,
  input  rlbe_pkg::status_t sts,
  output rlbe_pkg::cmd_t    cmd
);
  import rlbe_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      ST_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_last) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        cmd.idle = 1'b1;
        if (item_valid) begin
          cmd.capture = 1'b1;
          state_next  = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        cmd.sweep_clear = 1'b1;
        case (sts.action) inside
          ACT_FILL, ACT_FILL_START: state_next = ST_FILL;
          ACT_START:                state_next = ST_START;
          ACT_TICK: begin
            cmd.tick_read = 1'b1;
            state_next    = ST_COMMIT;
          end
          default:                  state_next = ST_COMMIT;
        endcase
      end
      ST_FILL: begin
        if (sts.fill_done) begin
          state_next = (sts.action == ACT_FILL_START) ? ST_START : ST_COMMIT;
        end else begin
          cmd.fill_step = 1'b1;
        end
      end
      ST_START: begin
        // A frame already going out keeps its buffers; the start is refused.
        if (sts.sending) begin
          cmd.start_reject = 1'b1;
          state_next       = ST_COMMIT;
        end else begin
          cmd.start_frame = 1'b1;
          state_next      = ST_COPY;
        end
      end
      ST_COPY: begin
        cmd.copy_step = 1'b1;
        if (sts.copy_done) state_next = ST_COMMIT;
      end
      ST_COMMIT: begin
        if (sts.out_free) begin
          cmd.commit = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_CLEAR;
    endcase
  end

endmodule

/* src/rlbe_datapath.sv */
module rlbe_datapath (
  input  logic                          clk,
  input  logic                          rst,
  input  rlbe_pkg::cmd_t                cmd,
  output rlbe_pkg::status_t             sts,
  input  logic                          cfg_we,
  input  logic [rlbe_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [rlbe_pkg::CFG_W-1:0]    cfg_data,
  input  logic [2:0]                    action,
  input  logic [7:0]                    led_index,
  input  logic [8:0]                    led_count,
  input  logic [7:0]                    green_level,
  input  logic [7:0]                    red_level,
  input  logic [7:0]                    blue_level,
  input  logic [7:0]                    white_level,
  input  logic                          res_stall,
  output logic                          res_valid,
  output logic [9:0]                    high_ticks,
  output logic [1:0]                    slot_kind,
  output logic                          frame_last,
  output logic                          accepted,
  output logic                          busy_res
);
  import rlbe_pkg::*;

  // Configuration registers.
  logic [9:0]  one_high;
  logic [9:0]  zero_high;
  logic [11:0] pause_slots;
  logic        white_en;

  // Captured item.
  logic [2:0]       it_action;
  logic [7:0]       it_index;
  logic [CNT_W-1:0] it_count;
  logic [31:0]      it_word;
  logic             it_ok;

  // Frame state.
  logic             sending_buffer;
  logic             sending_flag;
  logic [CNT_W-1:0] frame_leds;
  logic [CNT_W-1:0] led_cursor;
  logic [4:0]       bit_cursor;
  logic [11:0]      pause_cursor;
  logic [SWP_W-1:0] sweep;

  // Colour store: two buffers, the buffer bit is the top address bit.
  logic [31:0]       mem [MEM_DEPTH];
  logic [31:0]       rd_data;
  logic              mem_we;
  logic [MEM_AW-1:0] waddr;
  logic [31:0]       wdata;
  logic              mem_re;
  logic [MEM_AW-1:0] raddr;

  logic             edit_buffer;
  logic [CNT_W-1:0] count_clamped;
  logic             index_ok;
  logic             out_free;

  // Tick evaluation.
  logic        tick_active;
  logic        in_data;
  logic        bit_val;
  logic [5:0]  led_bits;
  logic [5:0]  bit_inc;
  logic        led_wrap;
  logic [11:0] pause_limit;
  logic [12:0] pause_inc;
  logic        pause_end;
  logic [9:0]  res_high;
  logic [1:0]  res_kind;
  logic        res_last;

  assign edit_buffer   = ~sending_buffer;
  assign count_clamped = (32'(led_count) > MAX_LEDS) ? CNT_W'(MAX_LEDS) : CNT_W'(led_count);
  assign index_ok      = 32'(led_index) < MAX_LEDS;
  assign out_free      = !res_valid || !res_stall;

  assign sts.action    = it_action;
  assign sts.sending   = sending_flag;
  assign sts.clr_last  = sweep == SWP_W'(MEM_DEPTH - 1);
  assign sts.fill_done = sweep == SWP_W'(it_count);
  assign sts.copy_done = sweep == SWP_W'(MAX_LEDS);
  assign sts.out_free  = out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      one_high    <= ONE_HIGH_RST;
      zero_high   <= ZERO_HIGH_RST;
      pause_slots <= PAUSE_RST;
      white_en    <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ONE_HIGH:  one_high    <= cfg_data[9:0];
        CFG_ZERO_HIGH: zero_high   <= cfg_data[9:0];
        CFG_PAUSE:     pause_slots <= cfg_data[11:0];
        CFG_WHITE:     white_en    <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      it_action <= action;
      it_index  <= led_index;
      it_count  <= count_clamped;
      it_word   <= {green_level, red_level, blue_level, white_level};
      it_ok     <= (action <= ACT_TICK) && ((action != ACT_WRITE_ONE) || index_ok);
    end else if (cmd.start_reject) begin
      it_ok <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sweep <= '0;
    end else if (cmd.sweep_clear || cmd.start_frame) begin
      sweep <= '0;
    end else if (cmd.clr_step || cmd.fill_step || cmd.copy_step) begin
      sweep <= sweep + 1'b1;
    end
  end

  // Write port: clearing pass, fill, copy and single writes never overlap.
  always_comb begin
    mem_we = 1'b0;
    waddr  = '0;
    wdata  = it_word;
    if (cmd.clr_step) begin
      mem_we = 1'b1;
      waddr  = sweep[MEM_AW-1:0];
      wdata  = '0;
    end else if (cmd.fill_step) begin
      mem_we = 1'b1;
      waddr  = {edit_buffer, sweep[LED_AW-1:0]};
    end else if (cmd.copy_step) begin
      // The copy writes one entry behind the read, as read data is registered.
      mem_we = sweep != '0;
      waddr  = {edit_buffer, LED_AW'(sweep - 1'b1)};
      wdata  = rd_data;
    end else if (cmd.commit && (it_action == ACT_WRITE_ONE) && it_ok) begin
      mem_we = 1'b1;
      waddr  = {edit_buffer, led_addr(it_index)};
    end
  end

  always_comb begin
    mem_re = 1'b0;
    raddr  = {sending_buffer, led_cursor[LED_AW-1:0]};
    if (cmd.copy_step) begin
      mem_re = sweep < SWP_W'(MAX_LEDS);
      raddr  = {sending_buffer, sweep[LED_AW-1:0]};
    end else if (cmd.tick_read) begin
      mem_re = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[waddr] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (mem_re) rd_data <= mem[raddr];
  end

  always_comb begin
    tick_active = (it_action == ACT_TICK) && sending_flag;
    in_data     = led_cursor < frame_leds;
    bit_val     = rd_data[5'd31 - bit_cursor];
    led_bits    = white_en ? BITS_RGBW : BITS_RGB;
    bit_inc     = {1'b0, bit_cursor} + 6'd1;
    led_wrap    = bit_inc >= led_bits;
    pause_limit = (pause_slots == '0) ? 12'd1 : pause_slots;
    pause_inc   = {1'b0, pause_cursor} + 13'd1;
    pause_end   = pause_inc >= {1'b0, pause_limit};
    res_high    = '0;
    res_kind    = SLOT_NONE;
    res_last    = 1'b0;
    if (tick_active) begin
      if (in_data) begin
        res_high = bit_val ? one_high : zero_high;
        res_kind = SLOT_DATA;
      end else begin
        res_kind = SLOT_PAUSE;
        res_last = pause_end;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sending_buffer <= 1'b0;
      sending_flag   <= 1'b0;
      frame_leds     <= '0;
      led_cursor     <= '0;
      bit_cursor     <= '0;
      pause_cursor   <= '0;
    end else if (cmd.start_frame) begin
      sending_buffer <= ~sending_buffer;
      sending_flag   <= 1'b1;
      frame_leds     <= it_count;
      led_cursor     <= '0;
      bit_cursor     <= '0;
      pause_cursor   <= '0;
    end else if (cmd.commit && tick_active) begin
      if (in_data) begin
        if (led_wrap) begin
          bit_cursor <= '0;
          led_cursor <= led_cursor + 1'b1;
        end else begin
          bit_cursor <= bit_inc[4:0];
        end
      end else if (pause_end) begin
        sending_flag <= 1'b0;
        pause_cursor <= '0;
      end else begin
        pause_cursor <= pause_inc[11:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (cmd.commit) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      high_ticks <= res_high;
      slot_kind  <= res_kind;
      frame_last <= res_last;
      accepted   <= it_ok;
      busy_res   <= sending_flag && !res_last;
    end
  end

endmodule

/* src/rgbw_led_chain_bit_encoder.sv */
// Channel  Signals                                        Handshake
// item     action, led_index, led_count, four levels      item_valid / item_stall
// result   high_ticks, slot_kind, frame_last, accepted,   res_valid / res_stall
//          busy_res
// config   cfg_index, cfg_data                            cfg_we, no wait
//
// Write one, tick or an undefined action pass dispatch and commit; a refused
// start adds a start step. A fill writes count entries before the commit. A start
// copies the sent buffer through the single write port of the colour store. Fill
// and start does the fill, then the start; a refused start skips the copy.
// After reset a clearing pass writes all 2 * MAX_LEDS store entries with
// item_stall high. An item is accepted while an earlier result still waits
// in the output register; the next one waits until that beat is taken.
module rgbw_led_chain_bit_encoder (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [rlbe_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [rlbe_pkg::CFG_W-1:0]    cfg_data,
  input  logic                          item_valid,
  output logic                          item_stall,
  input  logic [2:0]                    action,
  input  logic [7:0]                    led_index,
  input  logic [8:0]                    led_count,
  input  logic [7:0]                    green_level,
  input  logic [7:0]                    red_level,
  input  logic [7:0]                    blue_level,
  input  logic [7:0]                    white_level,
  output logic                          res_valid,
  input  logic                          res_stall,
  output logic [9:0]                    high_ticks,
  output logic [1:0]                    slot_kind,
  output logic                          frame_last,
  output logic                          accepted,
  output logic                          busy_res
);
  import rlbe_pkg::*;

  cmd_t    cmd;
  status_t sts;

  assign item_stall = !cmd.idle;

  rlbe_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .sts        (sts),
    .cmd        (cmd)
  );

  rlbe_datapath u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .sts         (sts),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .action      (action),
    .led_index   (led_index),
    .led_count   (led_count),
    .green_level (green_level),
    .red_level   (red_level),
    .blue_level  (blue_level),
    .white_level (white_level),
    .res_stall   (res_stall),
    .res_valid   (res_valid),
    .high_ticks  (high_ticks),
    .slot_kind   (slot_kind),
    .frame_last  (frame_last),
    .accepted    (accepted),
    .busy_res    (busy_res)
  );

endmodule

/* src/rlbe_checker.sv */
`include "rgbw_led_chain_bit_encoder_assert.svh"

module rlbe_checker (
  input logic       clk,
  input logic       rst,
  input logic       item_valid,
  input logic       item_stall,
  input logic       res_valid,
  input logic       res_stall,
  input logic [9:0] high_ticks,
  input logic [1:0] slot_kind,
  input logic       frame_last,
  input logic       accepted,
  input logic       busy_res
);
  import rlbe_pkg::*;

  // A held result beat keeps its payload.
  `RLBE_ASSERT_NEXT(a_res_hold, res_valid && res_stall, res_valid && $stable(high_ticks) && $stable(slot_kind) && $stable(frame_last), "result beat changed while stalled")

  // Items are worked one at a time, so an accepted beat is never followed at once.
  `RLBE_ASSERT_NEXT(a_one_at_a_time, item_valid && !item_stall, item_stall, "item taken in the cycle after another")

  // The frame ends on a pause slot and leaves the block idle.
  `RLBE_ASSERT_NOW(a_last_is_pause, res_valid && frame_last, (slot_kind == SLOT_PAUSE) && !busy_res, "frame end flagged outside a pause slot")

  // Only a taken tick gives a slot, and only a data slot has a high time.
  `RLBE_ASSERT_NOW(a_slot_ok, res_valid && (slot_kind != SLOT_NONE), accepted && ((slot_kind == SLOT_DATA) || (high_ticks == 10'd0)), "slot result inconsistent")

endmodule

bind rgbw_led_chain_bit_encoder rlbe_checker u_chk (.*);
